FILE: hdl/bcl_pkg.sv
`default_nettype none

package bcl_pkg;

	// Request codes as they arrive on req_type.
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_REM_FRONT = 3'd2,
		OP_REM_BACK  = 3'd3,
		OP_REM_AFTER = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_NOP       = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NOSUCC   = 3'd4
	} status_t;

	localparam int unsigned DataW = 32;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic                    fire;
		op_t                     op;
		logic signed [DataW-1:0] item;
	} cmd_t;

	// Removed-entry chain, handed from each cell to the next one.
	typedef struct packed {
		logic                    picked;
		logic signed [DataW-1:0] data;
	} take_t;

endpackage

`default_nettype wire

FILE: hdl/bcl_cell.sv
`default_nettype none

module bcl_cell #(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  wire logic                            clk,
	input  wire bcl_pkg::cmd_t                   cmd,
	input  wire logic [$clog2(DEPTH+1)-1:0]      count,
	input  wire logic signed [bcl_pkg::DataW-1:0] left_value,
	input  wire logic signed [bcl_pkg::DataW-1:0] right_value,
	input  wire logic                            hit_in,
	input  wire logic                            first_in,
	input  wire bcl_pkg::take_t                  take_in,
	output logic signed [bcl_pkg::DataW-1:0]      value_q,
	output logic                                 hit_out,
	output logic                                 first_out,
	output bcl_pkg::take_t                       take_out
);
	import bcl_pkg::*;

	localparam int CW = $clog2(DEPTH+1);

	logic valid;
	logic match;
	logic is_front;
	logic is_back;
	logic pick;

	assign valid    = CW'(IDX) < count;
	assign match    = valid && (value_q == cmd.item);
	assign hit_out  = hit_in || match;
	assign first_out = match && !hit_in;
	assign is_front = (IDX == 0);
	assign is_back  = (CW'(IDX + 1) == count);

	always_comb begin
		case (cmd.op)
			OP_REM_FRONT: pick = valid && is_front;
			OP_REM_BACK:  pick = valid && is_back;
			OP_REM_AFTER: pick = valid && first_in;
			default:      pick = 1'b0;
		endcase
	end

	assign take_out.picked = take_in.picked || pick;
	assign take_out.data   = pick ? value_q : take_in.data;

	// Shifting cells past the end of the list is harmless: they are not valid.
	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			case (cmd.op)
				OP_INS_FRONT: value_q <= left_value;
				OP_INS_BACK: begin
					if (CW'(IDX) == count) value_q <= cmd.item;
				end
				OP_REM_FRONT: value_q <= right_value;
				OP_REM_AFTER: begin
					if (hit_in) value_q <= right_value;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bounded_circular_list.sv
`default_nettype none

// Bounded ordered list of up to DEPTH signed 32-bit entries, front to back.
// A request transaction on req_* inserts at the front or back, removes the
// front, the back or the entry following the first match of item_value, or
// clears the list; each request returns one response transaction with a
// status, the removed value (zero when nothing is removed) and the new count.
// Inserting into a full list is dropped with status full; any removal from an
// empty list reports empty. Each request is applied to the cells when it is
// accepted, and a new request can be taken while the previous response is
// drained: the row of cells shifts and compares all entries at once, and the
// response sits in an output register so a request is accepted whenever that
// register is empty or being drained. No clearing pass is needed after reset.
module bounded_circular_list #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [2:0]                    req_type,
	input  wire logic signed [bcl_pkg::DataW-1:0] item_value,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output logic [2:0]                         status,
	output logic signed [bcl_pkg::DataW-1:0]    removed_value,
	output logic [$clog2(DEPTH+1)-1:0]         entry_count
);
	import bcl_pkg::*;

	localparam int CW = $clog2(DEPTH+1);

	logic [CW-1:0] count_q;
	logic          fire;
	logic          full;
	logic          empty;
	op_t           req_op;
	cmd_t          cmd;

	logic signed [DataW-1:0] cell_value [DEPTH];
	logic                    hit_chain [DEPTH+1];
	logic                    first_chain [DEPTH+1];
	take_t                   take_chain [DEPTH+1];

	status_t       next_status;
	logic [CW-1:0] next_count;

	// A request may enter while the response register is empty or draining.
	assign req_ready = !rsp_valid || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);

	// Decode the request; an insert into a full list or a removal from an
	// empty one becomes a no-op so that the cells stay untouched.
	always_comb begin
		case (req_type)
			OP_INS_FRONT, OP_INS_BACK: req_op = full ? OP_NOP : op_t'(req_type);
			OP_REM_FRONT, OP_REM_BACK, OP_REM_AFTER:
				req_op = empty ? OP_NOP : op_t'(req_type);
			OP_CLEAR: req_op = OP_CLEAR;
			default:  req_op = OP_NOP;
		endcase
	end

	assign cmd.fire = fire;
	assign cmd.op   = req_op;
	assign cmd.item = item_value;

	assign hit_chain[0]   = 1'b0;
	assign first_chain[0] = 1'b0;
	assign take_chain[0]  = '{picked: 1'b0, data: '0};

	// The row of cells: each entry in one cell; front inserts shift toward the
	// back and front or after removals close the gap from the back neighbor,
	// and the match and removed-value chains run front to back through the row.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DataW-1:0] left_v;
		logic signed [DataW-1:0] right_v;

		if (g == 0) begin : g_front
			assign left_v = item_value;
		end else begin : g_mid_l
			assign left_v = cell_value[g-1];
		end
		if (g == DEPTH - 1) begin : g_back
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_value[g+1];
		end

		bcl_cell #(
			.DEPTH(DEPTH),
			.IDX  (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_value (left_v),
			.right_value(right_v),
			.hit_in     (hit_chain[g]),
			.first_in   (first_chain[g]),
			.take_in    (take_chain[g]),
			.value_q    (cell_value[g]),
			.hit_out    (hit_chain[g+1]),
			.first_out  (first_chain[g+1]),
			.take_out   (take_chain[g+1])
		);
	end

	// Status and new count. A remove-after that finds a match but removes
	// nothing means the first match was the back entry.
	always_comb begin
		next_status = ST_OK;
		next_count  = count_q;
		case (req_type)
			OP_INS_FRONT, OP_INS_BACK: begin
				if (full) next_status = ST_FULL;
				else next_count = count_q + CW'(1);
			end
			OP_REM_FRONT, OP_REM_BACK: begin
				if (empty) next_status = ST_EMPTY;
				else next_count = count_q - CW'(1);
			end
			OP_REM_AFTER: begin
				if (empty) next_status = ST_EMPTY;
				else if (!hit_chain[DEPTH]) next_status = ST_NOTFOUND;
				else if (!take_chain[DEPTH].picked) next_status = ST_NOSUCC;
				else next_count = count_q - CW'(1);
			end
			OP_CLEAR: next_count = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (fire) begin
				count_q   <= next_count;
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Response payload; the removed-value chain is zero when nothing is picked.
	always_ff @(posedge clk) begin
		if (fire) begin
			status        <= next_status;
			removed_value <= take_chain[DEPTH].data;
			entry_count   <= next_count;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (entry_count == CW'(DEPTH)))
		else $error("full status with list not full");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (removed_value == '0))
		else $error("failed request reports a removed value");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count == count_q))
		else $error("reported count differs from list count");

endmodule

`default_nettype wire
